// ===== src/psfs_pkg.sv =====
package psfs_pkg;

  localparam int unsigned CountWidth = 8;
  localparam int unsigned LimitWidth = 8;

  localparam logic [CountWidth-1:0] CountMax   = '1;
  localparam logic [LimitWidth-1:0] LimitReset = 8'd3;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [LimitWidth-1:0] limit_t;

  // Per-tick control for one fault tracker.
  typedef struct packed {
    logic clr;  // supply reads normal: drop count and latch
    logic adv;  // supply reads faulty: advance count
  } fault_ctl_t;

  // Status of one fault tracker for the tick being processed.
  typedef struct packed {
    logic confirm;  // count exceeds limit after this tick
    logic evt;      // newly confirmed this tick
    logic latched;  // latch value after this tick
  } fault_stat_t;

endpackage

// ===== src/power_supply_fault_supervisor_core.sv =====
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+------------------------------------------
// in      | input     | in_valid_i / in_stall_o   | main_good_i, backup_bad_i, backup_open_i
// out     | output    | out_valid_o / out_stall_i | lamps, three events, sound_request_o,
//         |           |                           | power_ok_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (persist_limit)
//
// One beat per cycle sustained while the output is not stalled. An accepted beat sits in
// stage one; its result is registered into stage two unless the output is stalled.
// Stage one registers the input beat, stage two registers the result; the trackers
// update state as a beat moves from stage one to stage two.
// Reset clears all counts, latches and lamps and loads persist_limit with 3.
// A stall on a valid output beat holds the result stage and a full stage one; in_stall_o
// rises only when stage one is full and cannot advance.
module power_supply_fault_supervisor_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       main_good_i,
  input  logic       backup_bad_i,
  input  logic       backup_open_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       main_fault_lamp_o,
  output logic       backup_fault_lamp_o,
  output logic       main_loss_event_o,
  output logic       backup_open_event_o,
  output logic       backup_short_event_o,
  output logic       sound_request_o,
  output logic       power_ok_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  psfs_pkg::limit_t limit_q;

  logic in_valid_q;
  logic main_good_q, backup_bad_q, backup_open_q;
  logic out_ready, go;

  psfs_pkg::fault_ctl_t  main_ctl, open_ctl, short_ctl;
  psfs_pkg::fault_stat_t main_st, open_st, short_st;

  logic main_lamp_q, main_lamp_d;
  logic backup_lamp_q, backup_lamp_d;

  logic out_valid_q;
  logic main_ev_q, open_ev_q, short_ev_q, sound_q, power_ok_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= psfs_pkg::LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign go         = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      main_good_q   <= main_good_i;
      backup_bad_q  <= backup_bad_i;
      backup_open_q <= backup_open_i;
    end
  end

  assign main_ctl.clr  = go && main_good_q;
  assign main_ctl.adv  = go && !main_good_q;
  assign open_ctl.clr  = go && !backup_bad_q;
  assign open_ctl.adv  = go && backup_bad_q && backup_open_q;
  assign short_ctl.clr = go && !backup_bad_q;
  assign short_ctl.adv = go && backup_bad_q && !backup_open_q;

  psfs_fault_trk u_main_trk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (main_ctl),
    .limit_i (limit_q),
    .stat_o  (main_st)
  );

  psfs_fault_trk u_open_trk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (open_ctl),
    .limit_i (limit_q),
    .stat_o  (open_st)
  );

  psfs_fault_trk u_short_trk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (short_ctl),
    .limit_i (limit_q),
    .stat_o  (short_st)
  );

  // Lamps hold until the supply reads normal or a fault is confirmed.
  always_comb begin
    main_lamp_d = main_lamp_q;
    if (main_ctl.clr) begin
      main_lamp_d = 1'b0;
    end else if (main_st.confirm) begin
      main_lamp_d = 1'b1;
    end

    backup_lamp_d = backup_lamp_q;
    if (open_ctl.clr) begin
      backup_lamp_d = 1'b0;
    end else if (open_st.confirm || short_st.confirm) begin
      backup_lamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_lamp_q   <= 1'b0;
      backup_lamp_q <= 1'b0;
    end else begin
      main_lamp_q   <= main_lamp_d;
      backup_lamp_q <= backup_lamp_d;
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      main_ev_q  <= main_st.evt;
      open_ev_q  <= open_st.evt;
      short_ev_q <= short_st.evt;
      sound_q    <= main_st.evt || open_st.evt || short_st.evt;
      power_ok_q <= !(main_st.latched || open_st.latched || short_st.latched);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign main_fault_lamp_o    = main_lamp_q;
  assign backup_fault_lamp_o  = backup_lamp_q;
  assign main_loss_event_o    = main_ev_q;
  assign backup_open_event_o  = open_ev_q;
  assign backup_short_event_o = short_ev_q;
  assign sound_request_o      = sound_q;
  assign power_ok_o           = power_ok_q;

endmodule

// ===== src/psfs_fault_trk.sv =====
module psfs_fault_trk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psfs_pkg::fault_ctl_t ctl_i,
  input  psfs_pkg::limit_t     limit_i,
  output psfs_pkg::fault_stat_t stat_o
);

  psfs_pkg::count_t count_q, count_d, count_inc;
  logic             latched_q, latched_d;
  logic             confirm;

  // Saturate at the top of the range.
  assign count_inc = (count_q == psfs_pkg::CountMax) ? count_q
                                                      : count_q + psfs_pkg::count_t'(1);
  assign confirm   = ctl_i.adv && (count_inc > limit_i);

  always_comb begin
    count_d   = count_q;
    latched_d = latched_q;
    if (ctl_i.clr) begin
      count_d   = '0;
      latched_d = 1'b0;
    end else if (ctl_i.adv) begin
      count_d = count_inc;
      if (confirm) begin
        latched_d = 1'b1;
      end
    end
  end

  assign stat_o.confirm = confirm;
  assign stat_o.evt     = confirm && !latched_q;
  assign stat_o.latched = latched_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      latched_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      latched_q <= latched_d;
    end
  end

endmodule
